### design/ftb_pkg.sv
// ftb_pkg: shared types, codes and helper functions of the fragment test and blend block
// no dependencies; imported by fragment_test_and_blend

package ftb_pkg;

   // depth precision, bounded by the 16-bit depth fields
   localparam int DEPTH_BITS = 16;
   localparam logic [15:0] DEPTH_MASK =
      (DEPTH_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << DEPTH_BITS) - 32'd1);

   // enable_flags bit positions
   localparam int EN_DEPTH_TEST  = 0;
   localparam int EN_DEPTH_WRITE = 1;
   localparam int EN_ALPHA_TEST  = 2;
   localparam int EN_BLEND       = 3;
   localparam int EN_MODULATE    = 4;

   localparam logic [4:0] ENABLE_RESET = 5'd2;
   localparam logic [7:0] UNORM_MAX    = 8'd255;
   localparam logic [16:0] SUM_MAX     = 17'd65025;
   localparam logic [16:0] ROUND_HALF  = 17'd127;

   typedef enum logic [2:0] {
      CSR_ENABLE       = 3'd0,
      CSR_DEPTH_CMP    = 3'd1,
      CSR_ALPHA_CMP    = 3'd2,
      CSR_ALPHA_REF    = 3'd3,
      CSR_BLEND_SRC    = 3'd4,
      CSR_BLEND_DST    = 3'd5,
      CSR_SPARE6       = 3'd6,
      CSR_SPARE7       = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      CMP_NEVER    = 3'd0,
      CMP_LESS     = 3'd1,
      CMP_EQUAL    = 3'd2,
      CMP_LEQUAL   = 3'd3,
      CMP_GREATER  = 3'd4,
      CMP_NOTEQUAL = 3'd5,
      CMP_GEQUAL   = 3'd6,
      CMP_ALWAYS   = 3'd7
   } compare_type;

   typedef enum logic [3:0] {
      BF_ZERO          = 4'd0,
      BF_ONE           = 4'd1,
      BF_SRC_COLOR     = 4'd2,
      BF_INV_SRC_COLOR = 4'd3,
      BF_SRC_ALPHA     = 4'd4,
      BF_INV_SRC_ALPHA = 4'd5,
      BF_DST_ALPHA     = 4'd6,
      BF_INV_DST_ALPHA = 4'd7,
      BF_DST_COLOR     = 4'd8,
      BF_INV_DST_COLOR = 4'd9
   } blend_factor_type;

   typedef struct packed {
      logic [7:0]  src_red;
      logic [7:0]  src_green;
      logic [7:0]  src_blue;
      logic [7:0]  src_alpha;
      logic [7:0]  texel_red;
      logic [7:0]  texel_green;
      logic [7:0]  texel_blue;
      logic [7:0]  texel_alpha;
      logic [15:0] frag_depth;
      logic [15:0] stored_depth;
      logic [15:0] dst_pixel;
   } req_item_type;

   typedef struct packed {
      logic [15:0] pixel_out;
      logic        color_write;
      logic [15:0] depth_out;
      logic        depth_write;
   } rsp_item_type;

   function automatic logic compare_pass(input logic [2:0] fn, input logic [15:0] v,
                                         input logic [15:0] r);
      logic res;
      case (compare_type'(fn))
         CMP_NEVER:    res = 1'b0;
         CMP_LESS:     res = (v < r);
         CMP_EQUAL:    res = (v == r);
         CMP_LEQUAL:   res = (v <= r);
         CMP_GREATER:  res = (v > r);
         CMP_NOTEQUAL: res = (v != r);
         CMP_GEQUAL:   res = (v >= r);
         default:      res = 1'b1;
      endcase
      return res;
   endfunction

   // x/255 rounded down for x below 65280, reciprocal form
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [15:0] t;
      t = x + {8'd0, x[15:8]} + 16'd1;
      return t[15:8];
   endfunction

   // blend weight; destination alpha reads as full
   function automatic logic [7:0] blend_weight(input logic [3:0] kind, input logic [7:0] s_ch,
                                               input logic [7:0] s_a, input logic [7:0] d_ch);
      logic [7:0] w;
      case (blend_factor_type'(kind))
         BF_ZERO:          w = 8'd0;
         BF_SRC_COLOR:     w = s_ch;
         BF_INV_SRC_COLOR: w = UNORM_MAX - s_ch;
         BF_SRC_ALPHA:     w = s_a;
         BF_INV_SRC_ALPHA: w = UNORM_MAX - s_a;
         BF_DST_ALPHA:     w = UNORM_MAX;
         BF_INV_DST_ALPHA: w = 8'd0;
         BF_DST_COLOR:     w = d_ch;
         BF_INV_DST_COLOR: w = UNORM_MAX - d_ch;
         default:          w = UNORM_MAX;
      endcase
      return w;
   endfunction

endpackage

### design/fragment_test_and_blend.sv
// fragment_test_and_blend: four-stage raster back end (modulate, depth/alpha test, blend, pack)
// depends on ftb_pkg for item types, register codes and helper functions
//
//  channel   ports                               handshake
//  request   start, busy, req_item               taken when start && !busy
//  response  rsp_valid, rsp_item                 one-cycle strobe, no back-pressure
//  config    csr_valid, csr_ready, csr_index,    written when csr_valid && csr_ready
//            csr_data
//
// one item per cycle; each item passes through the stage 1 to stage 4 registers before its result appears.
// stage 1 holds the texel products, stage 2 the modulated color and depth test,
// stage 3 the blend products and alpha test, stage 4 the packed result register.
// busy stays low: the response side never stalls, so the pipe always advances.
// synchronous reset clears the valid bits and sets the configuration registers to their reset values.

module fragment_test_and_blend (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ftb_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   output ftb_pkg::rsp_item_type rsp_item,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [7:0]            csr_data
);
   import ftb_pkg::*;

   // configuration registers
   logic [4:0] enable_ff;
   logic [2:0] depth_cmp_ff;
   logic [2:0] alpha_cmp_ff;
   logic [7:0] alpha_ref_ff;
   logic [3:0] blend_src_ff;
   logic [3:0] blend_dst_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= ENABLE_RESET;
         depth_cmp_ff <= CMP_LESS;
         alpha_cmp_ff <= CMP_ALWAYS;
         alpha_ref_ff <= 8'd0;
         blend_src_ff <= BF_ONE;
         blend_dst_ff <= BF_ZERO;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_ENABLE:    enable_ff    <= csr_data[4:0];
            CSR_DEPTH_CMP: depth_cmp_ff <= csr_data[2:0];
            CSR_ALPHA_CMP: alpha_cmp_ff <= csr_data[2:0];
            CSR_ALPHA_REF: alpha_ref_ff <= csr_data;
            CSR_BLEND_SRC: blend_src_ff <= csr_data[3:0];
            CSR_BLEND_DST: blend_dst_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // ---------------- stage 1: texel products ----------------
   logic        v1_ff;
   logic [7:0]  src1_ff [4];
   logic [15:0] prod1_ff [4];
   logic [15:0] zf1_ff, zs1_ff, dst1_ff;

   logic [7:0] src_in [4];
   logic [7:0] tex_in [4];

   assign src_in[0] = req_item.src_red;
   assign src_in[1] = req_item.src_green;
   assign src_in[2] = req_item.src_blue;
   assign src_in[3] = req_item.src_alpha;
   assign tex_in[0] = req_item.texel_red;
   assign tex_in[1] = req_item.texel_green;
   assign tex_in[2] = req_item.texel_blue;
   assign tex_in[3] = req_item.texel_alpha;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= start && !busy;
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 4; c++) begin
         src1_ff[c]  <= src_in[c];
         prod1_ff[c] <= {8'd0, src_in[c]} * {8'd0, tex_in[c]};
      end
      zf1_ff  <= req_item.frag_depth & DEPTH_MASK;
      zs1_ff  <= req_item.stored_depth & DEPTH_MASK;
      dst1_ff <= req_item.dst_pixel;
   end

   // ---------------- stage 2: modulated color, depth test ----------------
   logic        v2_ff;
   logic [7:0]  s2_ff [4];
   logic [7:0]  d2_ff [3];
   logic        zpass2_ff;
   logic [15:0] zf2_ff, dst2_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 4; c++) begin
         s2_ff[c] <= enable_ff[EN_MODULATE] ? div255(prod1_ff[c] + ROUND_HALF[15:0])
                                            : src1_ff[c];
      end
      // destination expands by shifting, no bit replication
      d2_ff[0]  <= {dst1_ff[15:11], 3'd0};
      d2_ff[1]  <= {dst1_ff[10:5], 2'd0};
      d2_ff[2]  <= {dst1_ff[4:0], 3'd0};
      zpass2_ff <= !enable_ff[EN_DEPTH_TEST] || compare_pass(depth_cmp_ff, zf1_ff, zs1_ff);
      zf2_ff    <= zf1_ff;
      dst2_ff   <= dst1_ff;
   end

   // ---------------- stage 3: alpha test, blend products ----------------
   logic        v3_ff;
   logic [7:0]  s3_ff [3];
   logic [15:0] ps3_ff [3];
   logic [15:0] pd3_ff [3];
   logic        pass3_ff;
   logic [15:0] zf3_ff, dst3_ff;

   logic [7:0] ws [3];
   logic [7:0] wd [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         ws[c] = blend_weight(blend_src_ff, s2_ff[c], s2_ff[3], d2_ff[c]);
         wd[c] = blend_weight(blend_dst_ff, s2_ff[c], s2_ff[3], d2_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= v2_ff;
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         s3_ff[c]  <= s2_ff[c];
         ps3_ff[c] <= {8'd0, s2_ff[c]} * {8'd0, ws[c]};
         pd3_ff[c] <= {8'd0, d2_ff[c]} * {8'd0, wd[c]};
      end
      pass3_ff <= zpass2_ff && (!enable_ff[EN_ALPHA_TEST] ||
                  compare_pass(alpha_cmp_ff, {8'd0, s2_ff[3]}, {8'd0, alpha_ref_ff}));
      zf3_ff   <= zf2_ff;
      dst3_ff  <= dst2_ff;
   end

   // ---------------- stage 4: saturate, divide, pack ----------------
   logic         v4_ff;
   rsp_item_type rsp4_ff;
   logic [7:0]   o [3];
   logic [16:0]  sum [3];
   logic [16:0]  sat [3];
   logic [16:0]  rnd [3];
   rsp_item_type rsp_in;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum[c] = {1'b0, ps3_ff[c]} + {1'b0, pd3_ff[c]};
         sat[c] = (sum[c] > SUM_MAX) ? SUM_MAX : sum[c];
         rnd[c] = sat[c] + ROUND_HALF;
         o[c]   = enable_ff[EN_BLEND] ? div255(rnd[c][15:0]) : s3_ff[c];
      end
      rsp_in.pixel_out   = pass3_ff ? {o[0][7:3], o[1][7:2], o[2][7:3]} : dst3_ff;
      rsp_in.color_write = pass3_ff;
      rsp_in.depth_out   = zf3_ff;
      rsp_in.depth_write = pass3_ff && enable_ff[EN_DEPTH_TEST] && enable_ff[EN_DEPTH_WRITE];
   end

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else       v4_ff <= v3_ff;
   end

   always_ff @(posedge clock) begin
      rsp4_ff <= rsp_in;
   end

   assign rsp_valid = v4_ff;
   assign rsp_item  = rsp4_ff;

endmodule
